// File: sv/dro_pkg.sv
// Package for the scaled rectangle unit: field widths, operation codes
// and the request/response transaction structs. No dependencies.
`timescale 1ns / 1ps

package dro_pkg;

   localparam int COORD_BITS = 32;
   localparam int SIZE_BITS  = 32;
   localparam int SCALE_BITS = 6;
   localparam int FUNC_BITS  = 3;

   // Right/top edges need room for a corner plus an extent, with sign.
   localparam int EDGE_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
   // Extent computed as edge difference.
   localparam int DIFF_BITS = EDGE_BITS + 1;

   localparam logic [FUNC_BITS-1:0] FUNC_OVERLAP   = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_CONTAINS  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_INTERSECT = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_UNION     = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_RESCALE   = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_EXTEND    = 3'd5;

   typedef struct packed {
      logic        [FUNC_BITS-1:0]  func;
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic        [SIZE_BITS-1:0]  a_w;
      logic        [SIZE_BITS-1:0]  a_h;
      logic        [SCALE_BITS-1:0] a_scale;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic        [SIZE_BITS-1:0]  b_w;
      logic        [SIZE_BITS-1:0]  b_h;
      logic        [SCALE_BITS-1:0] b_scale;
      logic        [SCALE_BITS-1:0] target_scale;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] res_x;
      logic signed [COORD_BITS-1:0] res_y;
      logic        [SIZE_BITS-1:0]  res_w;
      logic        [SIZE_BITS-1:0]  res_h;
      logic        [SCALE_BITS-1:0] res_scale;
      logic                         ok;
      logic                         overflow;
   } rsp_type;

endpackage

// File: sv/dyadic_rect_ops.sv
// Scaled rectangle unit: overlap, containment, intersection and union
// (the last two at equal scales only), rescale and extend-by-point on
// rectangles with power-of-two scales. Depends on dro_pkg.
//
// Usage:
//   Present a request transaction on req_data and raise start. It is taken
//   at a rising edge where start is high and busy is low; busy stays low,
//   so one transaction can be taken every clock cycle.
//   The result appears on rsp_data with rsp_strobe high for exactly one
//   cycle. A request taken into the input register is evaluated
//   combinationally and captured in the result register, which drives rsp_data.
//   Throughput is one transaction per cycle; the input register and the
//   result register bracket one pass of shifters, adders and compares.
//   The receiver cannot stall: results must be captured when strobed.
//   Synchronous reset clears the pipeline valid flags; a request in
//   flight at reset is dropped and no strobe follows it.
`timescale 1ns / 1ps

module dyadic_rect_ops (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dro_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dro_pkg::rsp_type rsp_data
);
   import dro_pkg::*;

   localparam logic signed [EDGE_BITS-1:0] ONE_E = EDGE_BITS'(1);

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // Corners and edges at full width
   logic signed [EDGE_BITS-1:0] ax_e, ay_e, ar_e, at_e;
   logic signed [EDGE_BITS-1:0] bx_e, by_e, br_e, bt_e;

   // Finer (f) and coarser (c) rectangles for the tests
   logic                        sa_ge_sb;
   logic                        same_scale;
   logic [SCALE_BITS-1:0]       n_ab;
   logic signed [EDGE_BITS-1:0] fx, fy, fr, ft, cx, cy, cr, ct;
   logic signed [EDGE_BITS-1:0] fx_m1, fy_m1, fr_m1, ft_m1;
   logic signed [EDGE_BITS-1:0] fx_fl, fy_fl, fr_fl, ft_fl;
   logic signed [EDGE_BITS-1:0] fx_m1_fl, fy_m1_fl, fr_m1_fl, ft_m1_fl;
   logic                        overlap_hit, contain_hit;

   // Rescale paths
   logic                        scale_up;
   logic [SCALE_BITS-1:0]       n_up, n_dn;
   logic signed [COORD_BITS-1:0] x_up, y_up;
   logic [SIZE_BITS-1:0]        w_up, h_up;
   logic                        up_fits;
   logic signed [EDGE_BITS-1:0] dx, dy, dr, dt;

   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_strobe_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   function automatic rsp_type emit_box(
      input logic signed [EDGE_BITS-1:0] ex,
      input logic signed [EDGE_BITS-1:0] ey,
      input logic signed [EDGE_BITS-1:0] er,
      input logic signed [EDGE_BITS-1:0] et,
      input logic [SCALE_BITS-1:0]       scale
   );
      logic signed [DIFF_BITS-1:0] w;
      logic signed [DIFF_BITS-1:0] h;
      logic                        x_bad, y_bad, w_bad, h_bad;
      rsp_type                     r;
      w = DIFF_BITS'(er) - DIFF_BITS'(ex);
      h = DIFF_BITS'(et) - DIFF_BITS'(ey);
      x_bad = (ex[EDGE_BITS-1:COORD_BITS-1] != '0) && (ex[EDGE_BITS-1:COORD_BITS-1] != '1);
      y_bad = (ey[EDGE_BITS-1:COORD_BITS-1] != '0) && (ey[EDGE_BITS-1:COORD_BITS-1] != '1);
      w_bad = (w[DIFF_BITS-1:SIZE_BITS] != '0);
      h_bad = (h[DIFF_BITS-1:SIZE_BITS] != '0);
      r.res_x     = ex[COORD_BITS-1:0];
      r.res_y     = ey[COORD_BITS-1:0];
      r.res_w     = w[SIZE_BITS-1:0];
      r.res_h     = h[SIZE_BITS-1:0];
      r.res_scale = scale;
      r.ok        = 1'b1;
      r.overflow  = x_bad | y_bad | w_bad | h_bad;
      return r;
   endfunction

   always_comb begin
      ax_e = EDGE_BITS'(in_req_ff.a_x);
      ay_e = EDGE_BITS'(in_req_ff.a_y);
      bx_e = EDGE_BITS'(in_req_ff.b_x);
      by_e = EDGE_BITS'(in_req_ff.b_y);
      ar_e = ax_e + EDGE_BITS'(in_req_ff.a_w);
      at_e = ay_e + EDGE_BITS'(in_req_ff.a_h);
      br_e = bx_e + EDGE_BITS'(in_req_ff.b_w);
      bt_e = by_e + EDGE_BITS'(in_req_ff.b_h);
   end

   // Scaling the coarse box up by 2^n compares against the fine box's
   // edges scaled down: (p << n) <= q  <=>  p <= floor(q / 2^n), and
   // (p << n) >= q  <=>  p > floor((q - 1) / 2^n).
   always_comb begin
      sa_ge_sb   = (in_req_ff.a_scale >= in_req_ff.b_scale);
      same_scale = (in_req_ff.a_scale == in_req_ff.b_scale);
      n_ab       = sa_ge_sb ? (in_req_ff.a_scale - in_req_ff.b_scale)
                            : (in_req_ff.b_scale - in_req_ff.a_scale);
      fx = sa_ge_sb ? ax_e : bx_e;
      fy = sa_ge_sb ? ay_e : by_e;
      fr = sa_ge_sb ? ar_e : br_e;
      ft = sa_ge_sb ? at_e : bt_e;
      cx = sa_ge_sb ? bx_e : ax_e;
      cy = sa_ge_sb ? by_e : ay_e;
      cr = sa_ge_sb ? br_e : ar_e;
      ct = sa_ge_sb ? bt_e : at_e;

      fx_m1 = fx - ONE_E;
      fy_m1 = fy - ONE_E;
      fr_m1 = fr - ONE_E;
      ft_m1 = ft - ONE_E;

      fx_fl    = fx >>> n_ab;
      fy_fl    = fy >>> n_ab;
      fr_fl    = fr >>> n_ab;
      ft_fl    = ft >>> n_ab;
      fx_m1_fl = fx_m1 >>> n_ab;
      fy_m1_fl = fy_m1 >>> n_ab;
      fr_m1_fl = fr_m1 >>> n_ab;
      ft_m1_fl = ft_m1 >>> n_ab;

      overlap_hit = !((cr <= fx_fl) || (cx > fr_m1_fl)) &&
                    !((ct <= fy_fl) || (cy > ft_m1_fl));

      if (sa_ge_sb) begin
         // a is the fine box: b must sit inside it
         contain_hit = (cx > fx_m1_fl) && (cy > fy_m1_fl) &&
                       (cr <= fr_fl) && (ct <= ft_fl);
      end else begin
         // b is the fine box: a must enclose it
         contain_hit = (cx <= fx_fl) && (cy <= fy_fl) &&
                       (cr > fr_m1_fl) && (ct > ft_m1_fl);
      end
   end

   always_comb begin
      scale_up = (in_req_ff.target_scale >= in_req_ff.a_scale);
      n_up     = in_req_ff.target_scale - in_req_ff.a_scale;
      n_dn     = in_req_ff.a_scale - in_req_ff.target_scale;

      // Upward: a value fits if shifting back restores it
      x_up    = in_req_ff.a_x <<< n_up;
      y_up    = in_req_ff.a_y <<< n_up;
      w_up    = in_req_ff.a_w << n_up;
      h_up    = in_req_ff.a_h << n_up;
      up_fits = ((x_up >>> n_up) == in_req_ff.a_x) && ((y_up >>> n_up) == in_req_ff.a_y) &&
                ((w_up >> n_up) == in_req_ff.a_w) && ((h_up >> n_up) == in_req_ff.a_h);

      // Downward: floor the low edges, ceiling the high edges
      dx = ax_e >>> n_dn;
      dy = ay_e >>> n_dn;
      dr = ((ar_e - ONE_E) >>> n_dn) + ONE_E;
      dt = ((at_e - ONE_E) >>> n_dn) + ONE_E;
   end

   always_comb begin
      rsp_data_in = '0;
      unique case (in_req_ff.func)
         FUNC_OVERLAP: begin
            rsp_data_in.ok = overlap_hit;
         end
         FUNC_CONTAINS: begin
            rsp_data_in.ok = contain_hit;
         end
         FUNC_INTERSECT: begin
            if (same_scale && overlap_hit) begin
               rsp_data_in = emit_box((ax_e > bx_e) ? ax_e : bx_e,
                                      (ay_e > by_e) ? ay_e : by_e,
                                      (ar_e < br_e) ? ar_e : br_e,
                                      (at_e < bt_e) ? at_e : bt_e,
                                      in_req_ff.a_scale);
            end
         end
         FUNC_UNION: begin
            if (same_scale) begin
               rsp_data_in = emit_box((ax_e < bx_e) ? ax_e : bx_e,
                                      (ay_e < by_e) ? ay_e : by_e,
                                      (ar_e > br_e) ? ar_e : br_e,
                                      (at_e > bt_e) ? at_e : bt_e,
                                      in_req_ff.a_scale);
            end
         end
         FUNC_RESCALE: begin
            if (scale_up) begin
               rsp_data_in.res_x     = x_up;
               rsp_data_in.res_y     = y_up;
               rsp_data_in.res_w     = w_up;
               rsp_data_in.res_h     = h_up;
               rsp_data_in.res_scale = in_req_ff.target_scale;
               rsp_data_in.ok        = 1'b1;
               rsp_data_in.overflow  = ~up_fits;
            end else begin
               rsp_data_in = emit_box(dx, dy, dr, dt, in_req_ff.target_scale);
            end
         end
         FUNC_EXTEND: begin
            rsp_data_in = emit_box((ax_e < bx_e) ? ax_e : bx_e,
                                   (ay_e < by_e) ? ay_e : by_e,
                                   (ar_e > bx_e) ? ar_e : bx_e,
                                   (at_e > by_e) ? at_e : by_e,
                                   in_req_ff.a_scale);
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

endmodule

// File: sim/dyadic_rect_ops_test.sv
// Testbench for dyadic_rect_ops: directed and random rectangle requests,
// each result checked against an exact 128-bit model of the six operations.
// Depends on dro_pkg and the dyadic_rect_ops RTL.
`timescale 1ns / 1ps

module dyadic_rect_ops_test;
   import dro_pkg::*;

   typedef logic signed [127:0] wide_t;

   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7fff_ffff;
   localparam logic [SIZE_BITS-1:0]         SIZE_MAX  = 32'hffff_ffff;

   localparam int RANDOM_PER_PHASE = 283;
   localparam int IDLE_LIMIT       = 1000;
   localparam int REPORT_LIMIT     = 40;

   class rect_scoreboard;
      rsp_type predicted_rsp[$];
      int      errors;
      int      requests;
      int      func_count[8];
      int      ok_count;
      int      overflow_count;

      function new();
         errors = 0;
         requests = 0;
         ok_count = 0;
         overflow_count = 0;
         foreach (func_count[i]) func_count[i] = 0;
      endfunction

      // c is scaled up by n into the units of f
      function automatic logic rects_overlap(wide_t fx, wide_t fy, wide_t fr, wide_t ft,
                                             wide_t cx, wide_t cy, wide_t cr, wide_t ct,
                                             int unsigned n);
         return !(((cr <<< n) <= fx) || ((cx <<< n) >= fr) ||
                  ((ct <<< n) <= fy) || ((cy <<< n) >= ft));
      endfunction

      function automatic wide_t ceil_shr(wide_t v, int unsigned n);
         wide_t f;
         f = v >>> n;
         if ((f <<< n) != v) f = f + 1;
         return f;
      endfunction

      function automatic rsp_type pack_rect(wide_t x, wide_t y, wide_t r, wide_t t,
                                            logic [SCALE_BITS-1:0] scale);
         rsp_type o;
         wide_t   w;
         wide_t   h;
         w = r - x;
         h = t - y;
         o.res_x = x[COORD_BITS-1:0];
         o.res_y = y[COORD_BITS-1:0];
         o.res_w = w[SIZE_BITS-1:0];
         o.res_h = h[SIZE_BITS-1:0];
         o.res_scale = scale;
         o.ok = 1'b1;
         o.overflow = (x != wide_t'($signed(x[COORD_BITS-1:0]))) ||
                      (y != wide_t'($signed(y[COORD_BITS-1:0]))) ||
                      (w[127:SIZE_BITS] != '0) || (h[127:SIZE_BITS] != '0);
         return o;
      endfunction

      function automatic rsp_type compute_rect_op(req_type q);
         rsp_type     o;
         wide_t       ax, ay, ar, at, bx, by, br, bt;
         wide_t       rx, ry, rr, rt;
         int unsigned sa, sb, st, n;
         o = '0;
         sa = q.a_scale;
         sb = q.b_scale;
         st = q.target_scale;
         ax = $signed(q.a_x);
         ay = $signed(q.a_y);
         bx = $signed(q.b_x);
         by = $signed(q.b_y);
         ar = ax + wide_t'(q.a_w);
         at = ay + wide_t'(q.a_h);
         br = bx + wide_t'(q.b_w);
         bt = by + wide_t'(q.b_h);
         case (q.func)
            FUNC_OVERLAP: begin
               if (sa >= sb) o.ok = rects_overlap(ax, ay, ar, at, bx, by, br, bt, sa - sb);
               else o.ok = rects_overlap(bx, by, br, bt, ax, ay, ar, at, sb - sa);
            end
            FUNC_CONTAINS: begin
               if (sa >= sb) begin
                  n = sa - sb;
                  o.ok = ((bx <<< n) >= ax) && ((by <<< n) >= ay) &&
                         ((br <<< n) <= ar) && ((bt <<< n) <= at);
               end else begin
                  n = sb - sa;
                  o.ok = ((ax <<< n) <= bx) && ((ay <<< n) <= by) &&
                         ((ar <<< n) >= br) && ((at <<< n) >= bt);
               end
            end
            FUNC_INTERSECT: begin
               if (sa == sb && rects_overlap(ax, ay, ar, at, bx, by, br, bt, 0)) begin
                  rx = (ax > bx) ? ax : bx;
                  ry = (ay > by) ? ay : by;
                  rr = (ar < br) ? ar : br;
                  rt = (at < bt) ? at : bt;
                  o = pack_rect(rx, ry, rr, rt, q.a_scale);
               end
            end
            FUNC_UNION: begin
               if (sa == sb) begin
                  rx = (ax < bx) ? ax : bx;
                  ry = (ay < by) ? ay : by;
                  rr = (ar > br) ? ar : br;
                  rt = (at > bt) ? at : bt;
                  o = pack_rect(rx, ry, rr, rt, q.a_scale);
               end
            end
            FUNC_RESCALE: begin
               if (st >= sa) begin
                  n = st - sa;
                  rx = ax <<< n;
                  ry = ay <<< n;
                  rr = rx + ((ar - ax) <<< n);
                  rt = ry + ((at - ay) <<< n);
               end else begin
                  // lower edges round down, upper edges round up
                  n = sa - st;
                  rx = ax >>> n;
                  ry = ay >>> n;
                  rr = ceil_shr(ar, n);
                  rt = ceil_shr(at, n);
               end
               o = pack_rect(rx, ry, rr, rt, q.target_scale);
            end
            FUNC_EXTEND: begin
               rx = (ax < bx) ? ax : bx;
               ry = (ay < by) ? ay : by;
               rr = (ar > bx) ? ar : bx;
               rt = (at > by) ? at : by;
               o = pack_rect(rx, ry, rr, rt, q.a_scale);
            end
            default: o = '0;
         endcase
         return o;
      endfunction

      function void note_request(req_type q);
         requests++;
         func_count[q.func]++;
         predicted_rsp.push_back(compute_rect_op(q));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_rsp.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result with no transaction outstanding, expected none, actual %p",
                        $time, got);
            return;
         end
         want = predicted_rsp.pop_front();
         if (got.ok === 1'b1) ok_count++;
         if (got.overflow === 1'b1) overflow_count++;
         compare_field("res_x", want.res_x, got.res_x);
         compare_field("res_y", want.res_y, got.res_y);
         compare_field("res_w", want.res_w, got.res_w);
         compare_field("res_h", want.res_h, got.res_h);
         compare_field("res_scale", want.res_scale, got.res_scale);
         compare_field("ok", want.ok, got.ok);
         compare_field("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rect_scoreboard board;
   int             quiet_cycles = 0;

   dyadic_rect_ops DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 64) - 32;
         2: begin
            case ($urandom_range(3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   function automatic logic [SIZE_BITS-1:0] rand_extent();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 40);
         2: begin
            case ($urandom_range(2))
               0: return '0;
               1: return 1;
               default: return SIZE_MAX;
            endcase
         end
         default: return $urandom_range(0, 3000);
      endcase
   endfunction

   function automatic logic [SCALE_BITS-1:0] rand_scale();
      case ($urandom_range(3))
         0, 1: return 6'($urandom_range(0, 12));
         2: return 6'($urandom_range(0, 63));
         default: return $urandom_range(1) ? 6'd63 : 6'd0;
      endcase
   endfunction

   // mostly same or nearby scale, so that the equal-scale paths get exercised
   function automatic logic [SCALE_BITS-1:0] related_scale(logic [SCALE_BITS-1:0] base);
      case ($urandom_range(3))
         0, 1: return base;
         2: return 6'(base + $urandom_range(0, 6) - 3);
         default: return rand_scale();
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.func = ($urandom_range(99) < 6) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      q.a_x = rand_coord();
      q.a_y = rand_coord();
      q.a_w = rand_extent();
      q.a_h = rand_extent();
      q.a_scale = rand_scale();
      // place b near a half of the time so that tests can hit
      if ($urandom_range(1)) begin
         q.b_x = q.a_x + $urandom_range(0, 80) - 40;
         q.b_y = q.a_y + $urandom_range(0, 80) - 40;
      end else begin
         q.b_x = rand_coord();
         q.b_y = rand_coord();
      end
      q.b_w = rand_extent();
      q.b_h = rand_extent();
      q.b_scale = related_scale(q.a_scale);
      q.target_scale = related_scale(q.a_scale);
      return q;
   endfunction

   function automatic req_type make_request(
         logic [FUNC_BITS-1:0] func,
         logic signed [COORD_BITS-1:0] ax, logic signed [COORD_BITS-1:0] ay,
         logic [SIZE_BITS-1:0] aw, logic [SIZE_BITS-1:0] ah, logic [SCALE_BITS-1:0] as,
         logic signed [COORD_BITS-1:0] bx, logic signed [COORD_BITS-1:0] by,
         logic [SIZE_BITS-1:0] bw, logic [SIZE_BITS-1:0] bh, logic [SCALE_BITS-1:0] bs,
         logic [SCALE_BITS-1:0] ts);
      req_type q;
      q.func = func;
      q.a_x = ax;
      q.a_y = ay;
      q.a_w = aw;
      q.a_h = ah;
      q.a_scale = as;
      q.b_x = bx;
      q.b_y = by;
      q.b_w = bw;
      q.b_h = bh;
      q.b_scale = bs;
      q.target_scale = ts;
      return q;
   endfunction

   task automatic send_item(input req_type item, input int unsigned idle_pct);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      // idle for a geometric number of cycles, with junk on the data lines
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data <= random_request();
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) board.check_result(rsp_data);
         if (start && !busy) board.note_request(req_data);
      end
   end

   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_strobe === 1'b1)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("dyadic_rect_ops_test failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase_idle[3];
      phase_idle = '{0, 50, 22};
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(make_request(FUNC_OVERLAP, 0, 0, 10, 10, 4, 5, 5, 10, 10, 4, 0), 0);
      // shared edge only: no overlap
      send_item(make_request(FUNC_OVERLAP, 0, 0, 10, 10, 4, 10, 0, 5, 5, 4, 0), 0);
      send_item(make_request(FUNC_OVERLAP, 1, 1, 2, 2, 2, 10, 10, 4, 4, 5, 0), 0);
      send_item(make_request(FUNC_OVERLAP, 3, 3, 0, 5, 1, 0, 0, 8, 8, 1, 0), 0);
      send_item(make_request(FUNC_OVERLAP, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0,
                             COORD_MAX, COORD_MAX, 1, 1, 63, 0), 0);
      send_item(make_request(FUNC_CONTAINS, 0, 0, 100, 100, 3, 10, 10, 5, 5, 3, 0), 0);
      send_item(make_request(FUNC_CONTAINS, 0, 0, 100, 100, 3, 90, 90, 20, 5, 3, 0), 0);
      send_item(make_request(FUNC_CONTAINS, 0, 0, 4, 4, 1, 1, 1, 30, 30, 4, 0), 0);
      send_item(make_request(FUNC_CONTAINS, 0, 0, 64, 64, 6, 0, 0, 1, 1, 0, 0), 0);
      send_item(make_request(FUNC_CONTAINS, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 0,
                             -1, -1, 1, 1, 63, 0), 0);
      send_item(make_request(FUNC_INTERSECT, -5, -5, 10, 10, 0, 0, 0, 20, 20, 0, 0), 0);
      send_item(make_request(FUNC_INTERSECT, 0, 0, 5, 5, 2, 7, 7, 5, 5, 2, 0), 0);
      // mixed scales are refused
      send_item(make_request(FUNC_INTERSECT, 0, 0, 10, 10, 2, 1, 1, 4, 4, 3, 0), 0);
      send_item(make_request(FUNC_UNION, 1, 2, 3, 4, 7, -10, 20, 5, 5, 7, 0), 0);
      send_item(make_request(FUNC_UNION, 1, 2, 3, 4, 7, -10, 20, 5, 5, 8, 0), 0);
      send_item(make_request(FUNC_UNION, COORD_MIN, 0, 1, 1, 0,
                             COORD_MAX, 0, SIZE_MAX, 1, 0, 0), 0);
      send_item(make_request(FUNC_RESCALE, -3, 5, 7, 9, 2, 0, 0, 0, 0, 0, 6), 0);
      send_item(make_request(FUNC_RESCALE, -7, -9, 5, 3, 4, 0, 0, 0, 0, 0, 1), 0);
      send_item(make_request(FUNC_RESCALE, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX, 0,
                             0, 0, 0, 0, 0, 63), 0);
      send_item(make_request(FUNC_RESCALE, COORD_MIN, COORD_MAX, SIZE_MAX, 1, 63,
                             0, 0, 0, 0, 0, 0), 0);
      send_item(make_request(FUNC_RESCALE, 12, -12, 3, 4, 5, 0, 0, 0, 0, 0, 5), 0);
      send_item(make_request(FUNC_EXTEND, 0, 0, 10, 10, 3, 4, 4, 0, 0, 0, 0), 0);
      send_item(make_request(FUNC_EXTEND, 0, 0, 10, 10, 3, -20, 30, 0, 0, 0, 0), 0);
      send_item(make_request(FUNC_EXTEND, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, 9,
                             COORD_MIN, COORD_MIN, 0, 0, 0, 0), 0);
      send_item(make_request(FUNC_SPARE_6, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11), 0);
      send_item(make_request(FUNC_SPARE_7, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 0);

      foreach (phase_idle[p])
         for (int k = 0; k < RANDOM_PER_PHASE; k++) send_item(random_request(), phase_idle[p]);

      start <= 1'b0;
      // wait until every predicted result has been checked
      @(posedge clock);
      while (board.predicted_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Ran %0d requests: overlap %0d, contains %0d, intersect %0d, union %0d,",
               board.requests, board.func_count[FUNC_OVERLAP], board.func_count[FUNC_CONTAINS],
               board.func_count[FUNC_INTERSECT], board.func_count[FUNC_UNION]);
      $display("rescale %0d, extend %0d, spare codes %0d; %0d results ok, %0d overflowed",
               board.func_count[FUNC_RESCALE], board.func_count[FUNC_EXTEND],
               board.func_count[FUNC_SPARE_6] + board.func_count[FUNC_SPARE_7],
               board.ok_count, board.overflow_count);
      if (board.errors == 0)
         $display("dyadic_rect_ops_test passed");
      else
         $display("dyadic_rect_ops_test failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/dro_pkg.sv
sv/dyadic_rect_ops.sv
sim/dyadic_rect_ops_test.sv
